// ===== hdl/qstm_pkg.sv =====
// ----------------------------------------------------------------------------
// qstm_pkg: shared types and constants
// Widths and constants for the quaternion, scale and translate matrix block.
// ----------------------------------------------------------------------------
package qstm_pkg;
	localparam int W = 32;
	localparam int QBITS = 29;
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
	localparam int NUMW = 61;
	localparam int DENW = 61;
	localparam int NQ = 18;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [NUMW-1:0] num_t;
	typedef logic [DENW-1:0] den_t;
	typedef logic signed [17:0] rot_t;

	typedef struct packed {
		q16_t px;
		q16_t py;
		q16_t pz;
		q16_t sx;
		q16_t sy;
		q16_t sz;
	} side_t;
endpackage

// ===== hdl/qstm_div.sv =====
// ----------------------------------------------------------------------------
// qstm_div: pipelined restoring divider
// Computes round(|num|*65536/den) with the sign of num, one quotient bit per
// pipeline stage, stalls with the rest of the pipe.
// ----------------------------------------------------------------------------
module qstm_div (
	input  logic                 clk,
	input  logic                 en,
	input  qstm_pkg::num_t       num,
	input  qstm_pkg::den_t       den,
	output qstm_pkg::rot_t       quo
);
	localparam int NQ = qstm_pkg::NQ;
	localparam int DW = qstm_pkg::DENW;

	logic [DW:0]   rem_s [0:NQ];
	logic [DW-1:0] den_s [0:NQ];
	logic [NQ-1:0] q_s   [0:NQ];
	logic          neg_s [0:NQ];

	logic [DW-1:0] mag;
	logic [NQ:0]   qr;

	assign mag = num[DW-1] ? DW'(-num) : DW'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, mag};
			den_s[0] <= den;
			q_s[0]   <= '0;
			neg_s[0] <= num[DW-1];
		end
	end

	for (genvar i = 0; i < NQ; i++) begin : g_st
		logic [DW:0] r;
		logic [DW:0] t;
		always_comb begin
			r = (i == 0) ? rem_s[i] : {rem_s[i][DW-1:0], 1'b0};
			t = r - {1'b0, den_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= t[DW] ? r : t;
				q_s[i+1]   <= {q_s[i][NQ-2:0], ~t[DW]};
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	// The rounded quotient is at most 65536, so 17 magnitude bits suffice.
	assign qr = ({1'b0, q_s[NQ]} + (NQ+1)'(1)) >> 1;
	assign quo = neg_s[NQ] ? -$signed({1'b0, qr[NQ-2:0]}) : $signed({1'b0, qr[NQ-2:0]});
endmodule

// ===== hdl/quaternion_scale_translate_to_matrix.sv =====
// ----------------------------------------------------------------------------
// quaternion_scale_translate_to_matrix: frame to 4x4 affine matrix
// Normalizes the quaternion, builds scaled rotation rows and a position row.
// ----------------------------------------------------------------------------
// The four row words of a frame share the single output register, and the
// front of the pipe waits while they leave.
// A stall on the output freezes every stage.
// Reset clears valid bits and the row counter; data registers are not reset.
module quaternion_scale_translate_to_matrix (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  qstm_pkg::q16_t        quat_x,
	input  qstm_pkg::q16_t        quat_y,
	input  qstm_pkg::q16_t        quat_z,
	input  qstm_pkg::q16_t        quat_w,
	input  qstm_pkg::q16_t        pos_x,
	input  qstm_pkg::q16_t        pos_y,
	input  qstm_pkg::q16_t        pos_z,
	input  qstm_pkg::q16_t        scale_x,
	input  qstm_pkg::q16_t        scale_y,
	input  qstm_pkg::q16_t        scale_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            row_index,
	output qstm_pkg::q16_t        elem_0,
	output qstm_pkg::q16_t        elem_1,
	output qstm_pkg::q16_t        elem_2,
	output qstm_pkg::q16_t        elem_3,
	output logic                  saturated,
	output logic                  last_row
);
	localparam int NQ = qstm_pkg::NQ;
	localparam int DLY = NQ;
	localparam int NUMW = qstm_pkg::NUMW;

	logic en;
	logic adv;
	logic [1:0] row_q;
	logic hold_rows;

	// Stage 1: range reduction.
	logic v_s1, zero_s1;
	logic signed [29:0] x_s1, y_s1, z_s1, w_s1;
	qstm_pkg::side_t side_s1;
	// Stage 2: products.
	logic v_s2, zero_s2;
	logic signed [59:0] xx_s2, yy_s2, zz_s2, ww_s2, xy_s2, xz_s2, yz_s2, xw_s2, yw_s2, zw_s2;
	qstm_pkg::side_t side_s2;
	// Stage 3: numerators and norm.
	logic v_s3, zero_s3;
	qstm_pkg::num_t nm_s3 [0:8];
	qstm_pkg::den_t n_s3;
	qstm_pkg::side_t side_s3;

	logic v_d [0:DLY];
	logic z_d [0:DLY];
	qstm_pkg::side_t sd_d [0:DLY];
	qstm_pkg::rot_t quo [0:8];

	// Stage 4: rotation terms; stage 5: scale products, one row a cycle unless the output stalls.
	logic v_s4;
	logic [1:0] row_s4;
	qstm_pkg::side_t side_s4;
	logic signed [17:0] rot_s4 [0:8];
	logic signed [17:0] rot_sel [0:2];
	logic signed [49:0] p_s5 [0:2];
	logic v_s5;
	logic [1:0] row_s5;
	qstm_pkg::q16_t pos_s5 [0:2];

	// The front of the pipe waits while the row sequencer still has rows to send.
	assign en = ~(out_valid & out_stall);
	assign hold_rows = v_s4 & (row_q != 2'd3);
	assign adv = en & ~hold_rows;
	assign in_stall = ~adv;

	// Shift count from the largest magnitude; every component shifts alike.
	function automatic logic [1:0] sh_need(input qstm_pkg::q16_t v);
		logic [31:0] m;
		begin
			m = v[31] ? 32'(-v) : 32'(v);
			if (m >= 32'h2000_0000 << 2) sh_need = 2'd3;
			else if (m >= 32'h2000_0000 << 1) sh_need = 2'd2;
			else if (m >= 32'h2000_0000) sh_need = 2'd1;
			else sh_need = 2'd0;
		end
	endfunction

	function automatic logic signed [29:0] shrk(input qstm_pkg::q16_t v, input logic [1:0] k);
		logic [31:0] m;
		logic [31:0] s;
		begin
			m = v[31] ? 32'(-v) : 32'(v);
			s = m >> k;
			shrk = v[31] ? -$signed(s[29:0]) : $signed(s[29:0]);
		end
	endfunction

	logic [1:0] kx, ky, kz, kw, kmax;
	always_comb begin
		kx = sh_need(quat_x); ky = sh_need(quat_y);
		kz = sh_need(quat_z); kw = sh_need(quat_w);
		kmax = kx;
		if (ky > kmax) kmax = ky;
		if (kz > kmax) kmax = kz;
		if (kw > kmax) kmax = kw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid & ~in_stall;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= shrk(quat_x, kmax); y_s1 <= shrk(quat_y, kmax);
			z_s1 <= shrk(quat_z, kmax); w_s1 <= shrk(quat_w, kmax);
			zero_s1 <= (quat_x == '0) && (quat_y == '0) && (quat_z == '0) && (quat_w == '0);
			side_s1 <= '{px: pos_x, py: pos_y, pz: pos_z, sx: scale_x, sy: scale_y, sz: scale_z};

			xx_s2 <= x_s1 * x_s1; yy_s2 <= y_s1 * y_s1;
			zz_s2 <= z_s1 * z_s1; ww_s2 <= w_s1 * w_s1;
			xy_s2 <= x_s1 * y_s1; xz_s2 <= x_s1 * z_s1; yz_s2 <= y_s1 * z_s1;
			xw_s2 <= x_s1 * w_s1; yw_s2 <= y_s1 * w_s1; zw_s2 <= z_s1 * w_s1;
			zero_s2 <= zero_s1; side_s2 <= side_s1;

			nm_s3[0] <= NUMW'(ww_s2) + NUMW'(xx_s2) - NUMW'(yy_s2) - NUMW'(zz_s2);
			nm_s3[1] <= (NUMW'(xy_s2) + NUMW'(zw_s2)) <<< 1;
			nm_s3[2] <= (NUMW'(xz_s2) - NUMW'(yw_s2)) <<< 1;
			nm_s3[3] <= (NUMW'(xy_s2) - NUMW'(zw_s2)) <<< 1;
			nm_s3[4] <= NUMW'(ww_s2) - NUMW'(xx_s2) + NUMW'(yy_s2) - NUMW'(zz_s2);
			nm_s3[5] <= (NUMW'(yz_s2) + NUMW'(xw_s2)) <<< 1;
			nm_s3[6] <= (NUMW'(xz_s2) + NUMW'(yw_s2)) <<< 1;
			nm_s3[7] <= (NUMW'(yz_s2) - NUMW'(xw_s2)) <<< 1;
			nm_s3[8] <= NUMW'(ww_s2) - NUMW'(xx_s2) - NUMW'(yy_s2) + NUMW'(zz_s2);
			n_s3 <= qstm_pkg::DENW'(xx_s2) + qstm_pkg::DENW'(yy_s2)
				+ qstm_pkg::DENW'(zz_s2) + qstm_pkg::DENW'(ww_s2);
			zero_s3 <= zero_s2; side_s3 <= side_s2;
		end
	end

	for (genvar e = 0; e < 9; e++) begin : g_div
		qstm_pkg::den_t dn;
		// A zero norm only occurs with the identity case; keep the divider sane.
		assign dn = zero_s3 ? qstm_pkg::DENW'(1) : n_s3;
		qstm_div u_div (.clk(clk), .en(adv), .num(nm_s3[e]), .den(dn), .quo(quo[e]));
	end

	// Side data and valid follow the divider latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DLY; i++) v_d[i] <= 1'b0;
		end else if (adv) begin
			v_d[0] <= v_s3;
			for (int i = 1; i <= DLY; i++) v_d[i] <= v_d[i-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			z_d[0] <= zero_s3; sd_d[0] <= side_s3;
			for (int i = 1; i <= DLY; i++) begin
				z_d[i] <= z_d[i-1]; sd_d[i] <= sd_d[i-1];
			end
		end
	end

	// The divider output lines up with v_d[NQ]; the tail stage is a plain hold
	// register fed while the row sequencer is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			row_q <= 2'd0;
		end else if (en) begin
			if (hold_rows) begin
				row_q <= row_q + 2'd1;
			end else begin
				v_s4 <= v_d[NQ];
				row_q <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= sd_d[NQ];
			for (int e = 0; e < 9; e++) begin
				if (z_d[NQ]) rot_s4[e] <= (e == 0 || e == 4 || e == 8) ? 18'sd65536 : 18'sd0;
				else rot_s4[e] <= quo[e];
			end
		end
	end

	logic signed [31:0] sc_sel;
	always_comb begin
		case (row_q)
			2'd0: begin
				sc_sel = side_s4.sx;
				rot_sel[0] = rot_s4[0]; rot_sel[1] = rot_s4[1]; rot_sel[2] = rot_s4[2];
			end
			2'd1: begin
				sc_sel = side_s4.sy;
				rot_sel[0] = rot_s4[3]; rot_sel[1] = rot_s4[4]; rot_sel[2] = rot_s4[5];
			end
			default: begin
				sc_sel = side_s4.sz;
				rot_sel[0] = rot_s4[6]; rot_sel[1] = rot_s4[7]; rot_sel[2] = rot_s4[8];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s5 <= row_q;
			for (int j = 0; j < 3; j++) begin
				p_s5[j] <= rot_sel[j] * sc_sel;
			end
			pos_s5[0] <= side_s4.px; pos_s5[1] <= side_s4.py; pos_s5[2] <= side_s4.pz;
		end
	end

	function automatic logic [32:0] rnd_sat(input logic signed [49:0] p);
		logic [49:0] mg;
		logic [34:0] m;
		logic signed [35:0] v;
		begin
			mg = p[49] ? 50'(-p) : 50'(p);
			m = 35'((mg + 50'd32768) >> 16);
			v = p[49] ? -$signed({1'b0, m}) : $signed({1'b0, m});
			if (v > 36'sh07fffffff) rnd_sat = {1'b1, qstm_pkg::SAT_MAX};
			else if (v < -36'sh080000000) rnd_sat = {1'b1, qstm_pkg::SAT_MIN};
			else rnd_sat = {1'b0, v[31:0]};
		end
	endfunction

	logic [32:0] r0, r1, r2;
	assign r0 = rnd_sat(p_s5[0]);
	assign r1 = rnd_sat(p_s5[1]);
	assign r2 = rnd_sat(p_s5[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_index <= row_s5;
			last_row <= (row_s5 == 2'd3);
			if (row_s5 == 2'd3) begin
				elem_0 <= pos_s5[0]; elem_1 <= pos_s5[1]; elem_2 <= pos_s5[2];
				elem_3 <= qstm_pkg::ONE_Q16; saturated <= 1'b0;
			end else begin
				elem_0 <= r0[31:0]; elem_1 <= r1[31:0]; elem_2 <= r2[31:0];
				elem_3 <= '0; saturated <= r0[32] | r1[32] | r2[32];
			end
		end
	end

	a_row_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_row == (row_index == 2'd3))) else $error("last_row mismatch");
	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && row_index != 2'd3) |=> (out_valid && row_index == $past(row_index) + 2'd1))
		else $error("row order broken");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hold_rows |-> in_stall) else $error("input taken while rows pending");
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_row) |-> (!saturated && elem_3 == qstm_pkg::ONE_Q16))
		else $error("position row wrong");
endmodule
